>>> sv/vbd_pkg.sv
// Shared types, constants and helpers of the Video-1 16-bit block decoder.
// No dependencies; every other file imports this package.
package vbd_pkg;

    localparam int MAX_WIDTH_BLOCKS  = 512;
    localparam int MAX_HEIGHT_BLOCKS = 512;
    localparam int DIM_W  = 10;
    localparam int POS_W  = 9;
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    localparam logic [5:0] CTRL_SKIP = 6'b100001;

    localparam logic [15:0] CY_R = 16'd19595;
    localparam logic [15:0] CY_G = 16'd38470;
    localparam logic [15:0] CY_B = 16'd7471;
    localparam logic [15:0] CU_R = 16'd11059;
    localparam logic [15:0] CU_G = 16'd21709;
    localparam logic [15:0] CU_B = 16'd32768;
    localparam logic [15:0] CV_R = 16'd32768;
    localparam logic [15:0] CV_G = 16'd27439;
    localparam logic [15:0] CV_B = 16'd5329;
    localparam logic [25:0] Y_ROUND = 26'd32768;
    localparam logic [25:0] C_ROUND = 26'd8421375;

    typedef struct packed {
        logic [15:0] stream_word;
        logic        frame_end;
    } t_in_item;

    typedef struct packed {
        logic [10:0] pixel_row;
        logic [8:0]  block_column;
        logic [15:0] pixel0;
        logic [15:0] pixel1;
        logic [15:0] pixel2;
        logic [15:0] pixel3;
        logic        run_last;
    } t_out_item;

    typedef struct packed {
        logic [15:0]      cw;
        logic             eight;
        logic [7:0][14:0] col;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] x;
    } t_blk_cmd;

    typedef enum logic [4:0] {
        ST_AWAIT = 5'b00001,
        ST_FIRST = 5'b00010,
        ST_TWO   = 5'b00100,
        ST_EIGHT = 5'b01000,
        ST_SKIP  = 5'b10000
    } t_front_state;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > maxv) r = maxv;
        return r;
    endfunction

endpackage

>>> sv/vbd_front.sv
// Front end: parses stream words, tracks block position and skips, gathers colours.
// Depends on vbd_pkg; pushes finished block commands into vbd_queue.
module vbd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  vbd_pkg::t_in_item  i_in,
    input  logic               i_full,
    output logic               o_push,
    output vbd_pkg::t_blk_cmd  o_cmd
);
    import vbd_pkg::*;

    localparam logic [DIM_W-1:0] MAXW = DIM_W'(MAX_WIDTH_BLOCKS);
    localparam logic [DIM_W-1:0] MAXH = DIM_W'(MAX_HEIGHT_BLOCKS);

    t_front_state     r_state, n_state;
    logic [DIM_W-1:0] r_wb, n_wb, r_hb, n_hb;
    logic [POS_W-1:0] r_x, n_x, r_row, n_row;
    logic             r_done, n_done;
    logic [DIM_W-1:0] r_skip, n_skip;
    logic [15:0]      r_cw, n_cw;
    logic [3:0]       r_taken, n_taken;
    logic [7:0][14:0] r_col, n_col;

    logic [DIM_W-1:0] eff_w, eff_h, span, rem;
    logic [POS_W-1:0] adv_x, adv_row;
    logic             adv_done, accept, eight;
    logic [3:0]       taken_nx;
    logic [15:0]      w;

    assign o_ready = (r_state != ST_SKIP) && !i_full;
    assign accept  = i_valid && o_ready;
    assign w       = i_in.stream_word;
    assign eff_w   = eff_dim(r_wb, MAXW);
    assign eff_h   = eff_dim(r_hb, MAXH);
    assign span    = eff_w - {1'b0, r_x};
    assign rem     = r_skip - span;

    always_comb begin
        adv_x    = r_x + POS_W'(1);
        adv_row  = r_row;
        adv_done = r_done;
        if ({1'b0, adv_x} >= eff_w || adv_x == '0) begin
            adv_x = '0;
            if (r_row == '0) adv_done = 1'b1;
            else adv_row = r_row - POS_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_wb    = r_wb;
        n_hb    = r_hb;
        n_x     = r_x;
        n_row   = r_row;
        n_done  = r_done;
        n_skip  = r_skip;
        n_cw    = r_cw;
        n_taken = r_taken;
        n_col   = r_col;
        o_push  = 1'b0;
        eight   = (r_state == ST_EIGHT);
        taken_nx = r_taken + 4'd1;
        o_cmd.cw    = r_cw;
        o_cmd.eight = 1'b0;
        o_cmd.col   = r_col;
        o_cmd.row   = r_row;
        o_cmd.x     = r_x;
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) n_wb = i_cfg_data;
            else n_hb = i_cfg_data;
            n_state = ST_AWAIT;
            n_x     = '0;
            n_row   = POS_W'(eff_dim((i_cfg_idx == CFG_HEIGHT) ? i_cfg_data : r_hb, MAXH)
                      - DIM_W'(1));
            n_done  = 1'b0;
            n_skip  = '0;
            n_cw    = '0;
            n_taken = '0;
        end else if (r_state == ST_SKIP) begin
            if (r_skip < span) begin
                n_x     = r_x + r_skip[POS_W-1:0];
                n_skip  = '0;
                n_state = ST_AWAIT;
            end else begin
                n_x    = '0;
                n_skip = rem;
                if (r_row == '0) begin
                    n_done  = 1'b1;
                    n_skip  = '0;
                    n_state = ST_AWAIT;
                end else begin
                    n_row = r_row - POS_W'(1);
                    if (rem == '0) n_state = ST_AWAIT;
                end
            end
        end else if (accept) begin
            if (!r_done) begin
                unique case (r_state)
                    ST_AWAIT: begin
                        if (w[15]) begin
                            if (w[15:10] == CTRL_SKIP) begin
                                n_skip  = (w[9:0] == '0) ? DIM_W'(1) : w[9:0];
                                n_state = ST_SKIP;
                            end else begin
                                o_push      = 1'b1;
                                o_cmd.cw    = 16'hFFFF;
                                o_cmd.col[0] = w[14:0];
                                n_x    = adv_x;
                                n_row  = adv_row;
                                n_done = adv_done;
                            end
                        end else begin
                            n_cw    = w;
                            n_state = ST_FIRST;
                            n_taken = '0;
                        end
                    end
                    ST_FIRST, ST_TWO, ST_EIGHT: begin
                        n_col[r_taken[2:0]] = w[14:0];
                        if (r_state == ST_FIRST) eight = w[15];
                        n_state = eight ? ST_EIGHT : ST_TWO;
                        n_taken = taken_nx;
                        if (taken_nx >= (eight ? 4'd8 : 4'd2)) begin
                            o_push      = 1'b1;
                            o_cmd.eight = eight;
                            o_cmd.col   = n_col;
                            n_x     = adv_x;
                            n_row   = adv_row;
                            n_done  = adv_done;
                            n_state = ST_AWAIT;
                            n_taken = '0;
                        end
                    end
                    default: n_state = ST_AWAIT;
                endcase
            end
            if (i_in.frame_end) begin
                n_state = ST_AWAIT;
                n_x     = '0;
                n_row   = POS_W'(eff_h - DIM_W'(1));
                n_done  = 1'b0;
                n_skip  = '0;
                n_cw    = '0;
                n_taken = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_AWAIT;
            r_wb    <= DIM_W'(1);
            r_hb    <= DIM_W'(1);
            r_x     <= '0;
            r_row   <= '0;
            r_done  <= 1'b0;
            r_skip  <= '0;
            r_cw    <= '0;
            r_taken <= '0;
        end else begin
            r_state <= n_state;
            r_wb    <= n_wb;
            r_hb    <= n_hb;
            r_x     <= n_x;
            r_row   <= n_row;
            r_done  <= n_done;
            r_skip  <= n_skip;
            r_cw    <= n_cw;
            r_taken <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

endmodule

>>> sv/vbd_queue.sv
// Two-entry command queue between front end and pixel back end.
// Depends on vbd_pkg.
module vbd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vbd_pkg::t_blk_cmd  i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output vbd_pkg::t_blk_cmd  o_cmd
);
    import vbd_pkg::*;

    t_blk_cmd       r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QAW'(1);
            if (i_pop) r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) i_push |-> (!o_full || i_pop);
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_no_underflow;
        @(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid;
    endproperty
    a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= (QAW+1)'(QDEPTH);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

endmodule

>>> sv/vbd_back.sv
// Back end: expands a block command into four pixel rows, RGB555 to YUY2.
// Depends on vbd_pkg; three-stage pipeline, last stage is the output register.
module vbd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_qvalid,
    input  vbd_pkg::t_blk_cmd  i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output vbd_pkg::t_out_item o_res
);
    import vbd_pkg::*;

    logic            en;
    logic [1:0]      r_i;
    logic            r_v1, r_v2, r_v3;
    logic [3:0][14:0] r_rgb1;
    logic [10:0]     r_prow1, r_prow2;
    logic [8:0]      r_x1, r_x2;
    logic            r_last1, r_last2;
    logic [3:0][2:0][20:0] r_py, r_pc;
    logic [3:0][15:0] pix;
    t_out_item       r_out;

    assign en    = !r_v3 || i_ready;
    assign o_pop = i_qvalid && en && (r_i == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i  <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            if (i_qvalid) r_i <= r_i + 2'd1;
            r_v1 <= i_qvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                r_rgb1[c] <= i_cmd.col[{(i_cmd.eight ? {~r_i[1], 1'(c >> 1)} : 2'b00),
                                        ~i_cmd.cw[{~r_i, 2'(c)}]}];
            end
            r_prow1 <= {i_cmd.row, r_i};
            r_x1    <= i_cmd.x;
            r_last1 <= (r_i == 2'd3);

            for (int c = 0; c < 4; c++) begin
                r_py[c][0] <= 21'(r_rgb1[c][14:10]) * 21'(CY_R);
                r_py[c][1] <= 21'(r_rgb1[c][9:5])   * 21'(CY_G);
                r_py[c][2] <= 21'(r_rgb1[c][4:0])   * 21'(CY_B);
                r_pc[c][0] <= 21'(r_rgb1[c][14:10]) * 21'(c[0] ? CV_R : CU_R);
                r_pc[c][1] <= 21'(r_rgb1[c][9:5])   * 21'(c[0] ? CV_G : CU_G);
                r_pc[c][2] <= 21'(r_rgb1[c][4:0])   * 21'(c[0] ? CV_B : CU_B);
            end
            r_prow2 <= r_prow1;
            r_x2    <= r_x1;
            r_last2 <= r_last1;

            r_out.pixel_row    <= r_prow2;
            r_out.block_column <= r_x2;
            r_out.pixel0       <= pix[0];
            r_out.pixel1       <= pix[1];
            r_out.pixel2       <= pix[2];
            r_out.pixel3       <= pix[3];
            r_out.run_last     <= r_last2;
        end
    end

    always_comb begin
        logic [25:0] ys, cs;
        for (int c = 0; c < 4; c++) begin
            ys = ((26'(r_py[c][0]) + 26'(r_py[c][1]) + 26'(r_py[c][2])) << 3) + Y_ROUND;
            if (c[0])
                cs = ((26'(r_pc[c][0]) - 26'(r_pc[c][1]) - 26'(r_pc[c][2])) << 3) + C_ROUND;
            else
                cs = ((26'(r_pc[c][2]) - 26'(r_pc[c][0]) - 26'(r_pc[c][1])) << 3) + C_ROUND;
            pix[c] = {cs[23:16], ys[23:16]};
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_out;

    property p_last_row;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_valid |-> (o_res.run_last == (o_res.pixel_row[1:0] == 2'd3));
    endproperty
    a_last_row: assert property (p_last_row) else $error("run_last out of step with row");

    property p_pop_on_fourth;
        @(posedge i_clk) disable iff (!i_rst_n) o_pop |=> (r_i == 2'd0);
    endproperty
    a_pop_on_fourth: assert property (p_pop_on_fourth) else $error("row counter misaligned");

    property p_stall_freeze;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_v3 && !i_ready) |=> ($stable(r_i) && $stable(r_v2));
    endproperty
    a_stall_freeze: assert property (p_stall_freeze) else $error("pipeline moved in stall");

endmodule

>>> sv/video1_block_decoder_unit.sv
// Top level of the Video-1 16-bit block decoder.
// Depends on vbd_pkg, vbd_front, vbd_queue, vbd_back.
//
// Input channel: one 16-bit stream word per transfer (i_valid/o_ready), with
// frame_end marking the last word of a frame. Output channel: one pixel row of
// a 4x4 block per transfer (o_valid/i_ready); four rows per decoded block,
// run_last on the fourth. Skipped blocks give no rows.
// Configuration: i_cfg_we writes width (index 0) or height (index 1) in
// blocks; a write restarts the frame position. Write only while idle.
// Throughput: one word per cycle while the block queue has room. A skip word
// holds o_ready low while the decoder steps over the skipped blocks row by row.
// The back end emits one row per cycle while the receiver is ready, four rows
// per block, so a stream of fill words is paced by the back end.
// Reset: position to the bottom-left block of a 1x1 grid, queue and pipeline
// empty. When the receiver stalls the back pipeline freezes, the two-entry
// queue fills, and then o_ready drops.
module video1_block_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  vbd_pkg::t_in_item  i_in,
    output logic               o_valid,
    input  logic               i_ready,
    output vbd_pkg::t_out_item o_res
);
    import vbd_pkg::*;

    logic     push, full, pop, qvalid;
    t_blk_cmd cmd_in, cmd_out;

    vbd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_in(i_in),
        .i_full(full), .o_push(push), .o_cmd(cmd_in)
    );

    vbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(cmd_in), .o_full(full),
        .i_pop(pop), .o_valid(qvalid), .o_cmd(cmd_out)
    );

    vbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_qvalid(qvalid), .i_cmd(cmd_out), .o_pop(pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

endmodule
